// ===== rtl/psf_pkg.sv =====
// Shared widths, register indexes and helpers for the pendulum state feedback unit.
// No dependencies.
package psf_pkg;

  localparam int ANGLE_W = 16;
  localparam int CMD_W   = 8;
  localparam int DRIVE_W = 16;
  localparam int REF_W   = 32;
  localparam int CFG_W   = 24;
  localparam int CFG_IDX_W = 3;
  localparam int ERR_W   = 48;
  // accumulator: |volts| < 2^57, times a 16-bit scale
  localparam int ACC_W   = 80;

  localparam int RAD_PER_UNIT   = 206;
  localparam int RAD_PER_DEGREE = 1144;
  localparam int UPRIGHT_LIMIT  = 90;
  localparam int CMD_START = 100;
  localparam int CMD_STOP  = -100;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_ARM      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_PEN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_ARM_RATE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_PEN_RATE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_INT      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_SCALE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SWING_PERIOD  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SWING_AMP     = 3'd7;

  // raw angle (or angle difference) to radians, Q16.16
  function automatic logic signed [24:0] to_rad(input logic signed [16:0] x);
    logic signed [24:0] xe;
    xe = 25'(x);
    return xe * 25'(RAD_PER_UNIT);
  endfunction

endpackage

// ===== rtl/psf_in_if.sv =====
// Input channel of the pendulum state feedback unit: one control tick per transaction.
// Depends on psf_pkg.
interface psf_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [psf_pkg::ANGLE_W-1:0]  pendulum_angle;
  logic signed [psf_pkg::ANGLE_W-1:0]  arm_angle;
  logic                                command_valid;
  logic signed [psf_pkg::CMD_W-1:0]    command;

  modport source (output valid, pendulum_angle, arm_angle, command_valid, command,
                  input ready);
  modport sink   (input valid, pendulum_angle, arm_angle, command_valid, command,
                  output ready);
endinterface

// ===== rtl/psf_out_if.sv =====
// Output channel of the pendulum state feedback unit: drive count and reference.
// Depends on psf_pkg.
interface psf_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [psf_pkg::DRIVE_W-1:0]  drive_value;
  logic signed [psf_pkg::REF_W-1:0]    reference_now;

  modport source (output valid, drive_value, reference_now, input ready);
  modport sink   (input valid, drive_value, reference_now, output ready);
endinterface

// ===== rtl/pendulum_state_feedback_pi_unit.sv =====
// Pendulum state feedback controller with PI integrator, bit-serial datapath.
// Steps per transaction: arm, pendulum, arm-rate and pendulum-rate products (16/16/24/24
// multiplier bits), the integrator product (16 bits, skipped outside the upright window),
// a prep state, the 16-bit drive scale product, then output valid held until ready. A new
// transaction is taken only in idle, after the output is taken: one shared serial multiplier.
// Reset: rst_ni async active low; state zero, registers to their default gains.
module pendulum_state_feedback_pi_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [psf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [psf_pkg::CFG_W-1:0]        cfg_data_i,
  psf_in_if.sink                           in_i,
  psf_out_if.source                        out_o
);

  localparam int AW = psf_pkg::ACC_W;

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_PREP = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  // product phases of the serial multiplier
  localparam logic [2:0] PH_ARM      = 3'd0;
  localparam logic [2:0] PH_PEN      = 3'd1;
  localparam logic [2:0] PH_ARM_RATE = 3'd2;
  localparam logic [2:0] PH_PEN_RATE = 3'd3;
  localparam logic [2:0] PH_INT      = 3'd4;
  localparam logic [2:0] PH_DRIVE    = 3'd5;

  // configuration registers
  logic signed [15:0] gain_arm_q, gain_pen_q, gain_int_q;
  logic signed [23:0] gain_arm_rate_q, gain_pen_rate_q;
  logic [15:0]        drive_scale_q, swing_period_q;
  logic [17:0]        swing_amp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_arm_q      <= -16'sd1004;
      gain_pen_q      <= 16'sd14170;
      gain_arm_rate_q <= -24'sd500053;
      gain_pen_rate_q <= 24'sd909653;
      gain_int_q      <= -16'sd277;
      drive_scale_q   <= 16'd17044;
      swing_period_q  <= 16'd3300;
      swing_amp_q     <= 18'd26214;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        psf_pkg::REG_GAIN_ARM:      gain_arm_q      <= cfg_data_i[15:0];
        psf_pkg::REG_GAIN_PEN:      gain_pen_q      <= cfg_data_i[15:0];
        psf_pkg::REG_GAIN_ARM_RATE: gain_arm_rate_q <= cfg_data_i;
        psf_pkg::REG_GAIN_PEN_RATE: gain_pen_rate_q <= cfg_data_i;
        psf_pkg::REG_GAIN_INT:      gain_int_q      <= cfg_data_i[15:0];
        psf_pkg::REG_DRIVE_SCALE:   drive_scale_q   <= cfg_data_i[15:0];
        psf_pkg::REG_SWING_PERIOD:  swing_period_q  <= cfg_data_i[15:0];
        psf_pkg::REG_SWING_AMP:     swing_amp_q     <= cfg_data_i[17:0];
        default: ;
      endcase
    end
  end

  // control state
  logic [1:0]  state_q;
  logic [2:0]  ph_q;
  logic [4:0]  cnt_q;
  logic        sgn_q;       // multiplier operand is two's complement
  logic        upright_q;
  logic        neg_q;       // sign of volts
  logic signed [15:0] prev_pen_q, prev_arm_q;
  logic signed [psf_pkg::ERR_W-1:0] err_sum_q;
  logic signed [31:0] ref_q;
  logic        swinging_q;
  logic [15:0] tick_q;

  // operands latched per transaction
  logic signed [15:0] pen_q, arm_q;
  logic signed [16:0] pen_dq, arm_dq;

  // serial multiplier: m shifts left, q shifts right one bit per cycle
  logic signed [AW-1:0] acc_q, m_q, fb_q;
  logic [23:0]          q_q;

  logic signed [15:0] drive_q;

  logic in_fire, out_fire;
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign out_o.valid = (state_q == ST_OUT);
  assign out_o.drive_value = drive_q;
  assign out_o.reference_now = ref_q;

  // reference and tick update for the incoming transaction
  logic [15:0]        tick_inc, tick_nx;
  logic signed [31:0] ref_cmd, ref_nx;
  logic               sw_nx;
  logic signed [31:0] amp_s;

  always_comb begin
    amp_s   = 32'($unsigned(swing_amp_q));
    tick_inc = (tick_q == 16'hFFFF) ? tick_q : tick_q + 16'd1;
    tick_nx = tick_inc;
    ref_nx  = ref_q;
    sw_nx   = swinging_q;
    ref_cmd = 32'(in_i.command) * 32'(psf_pkg::RAD_PER_DEGREE);
    if (in_i.command_valid) begin
      if (in_i.command == 8'(psf_pkg::CMD_START)) begin
        ref_nx  = amp_s;
        tick_nx = '0;
        sw_nx   = 1'b1;
      end else if (in_i.command == 8'(psf_pkg::CMD_STOP)) begin
        ref_nx = '0;
        sw_nx  = 1'b0;
      end else begin
        ref_nx = ref_cmd;
        sw_nx  = 1'b0;
      end
    end
    if (sw_nx && (tick_nx > swing_period_q)) begin
      ref_nx  = (ref_nx > 32'sd0) ? -amp_s : amp_s;
      tick_nx = '0;
    end
  end

  // one multiplier bit; the top bit of a signed operand has negative weight
  logic                 last;
  logic signed [AW-1:0] addend, acc_nx;

  always_comb begin
    last = (cnt_q == 5'd0);
    if (!q_q[0])            addend = '0;
    else if (last && sgn_q) addend = -m_q;
    else                    addend = m_q;
    acc_nx = acc_q + addend;
  end

  // operand selection for the next phase, integrator saturation, volts and drive clamping
  logic signed [24:0] arm_rad, pen_rad, arm_drad, pen_drad;
  logic signed [32:0] err;
  logic signed [AW-1:0] es_ext, err_max, err_min, es_sat, volts, mag;
  logic [39:0] counts;
  logic signed [15:0] drive_nx;

  always_comb begin
    arm_rad  = psf_pkg::to_rad(17'(arm_q));
    pen_rad  = psf_pkg::to_rad(17'(pen_q));
    arm_drad = psf_pkg::to_rad(arm_dq);
    pen_drad = psf_pkg::to_rad(pen_dq);
    err      = 33'(arm_rad) - 33'(ref_q);
    es_ext   = AW'(err_sum_q);
    err_max  = AW'({1'b0, {(psf_pkg::ERR_W-1){1'b1}}});
    err_min  = -err_max - AW'(1);
    if (acc_nx > err_max)      es_sat = err_max;
    else if (acc_nx < err_min) es_sat = err_min;
    else                       es_sat = acc_nx;
    volts = -es_ext - (fb_q <<< 8);
    mag   = (volts < 0) ? -volts : volts;
    counts = acc_nx[AW-1:40];
    if (neg_q)
      drive_nx = (counts > 40'd32768) ? -16'sd32768 : -$signed(counts[15:0]);
    else
      drive_nx = (counts > 40'd32767) ? 16'sd32767 : $signed(counts[15:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      ph_q       <= PH_ARM;
      cnt_q      <= '0;
      sgn_q      <= 1'b0;
      upright_q  <= 1'b0;
      neg_q      <= 1'b0;
      prev_pen_q <= '0;
      prev_arm_q <= '0;
      err_sum_q  <= '0;
      ref_q      <= '0;
      swinging_q <= 1'b0;
      tick_q     <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            ref_q      <= ref_nx;
            swinging_q <= sw_nx;
            tick_q     <= tick_nx;
            upright_q  <= (in_i.pendulum_angle > -16'(psf_pkg::UPRIGHT_LIMIT)) &&
                          (in_i.pendulum_angle < 16'(psf_pkg::UPRIGHT_LIMIT));
            prev_pen_q <= in_i.pendulum_angle;
            prev_arm_q <= in_i.arm_angle;
            ph_q       <= PH_ARM;
            cnt_q      <= 5'd15;
            sgn_q      <= 1'b1;
            state_q    <= ST_MUL;
          end
        end
        ST_MUL: begin
          cnt_q <= cnt_q - 5'd1;
          if (last) begin
            case (ph_q)
              PH_ARM: begin
                ph_q <= PH_PEN;  cnt_q <= 5'd15;
              end
              PH_PEN: begin
                ph_q <= PH_ARM_RATE;  cnt_q <= 5'd23;
              end
              PH_ARM_RATE: begin
                ph_q <= PH_PEN_RATE;  cnt_q <= 5'd23;
              end
              PH_PEN_RATE: begin
                if (upright_q) begin
                  ph_q <= PH_INT;  cnt_q <= 5'd15;
                end else begin
                  err_sum_q <= '0;
                  state_q   <= ST_PREP;
                end
              end
              PH_INT: begin
                err_sum_q <= es_sat[psf_pkg::ERR_W-1:0];
                state_q   <= ST_PREP;
              end
              PH_DRIVE: begin
                state_q <= ST_OUT;
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end
        ST_PREP: begin
          neg_q   <= (volts < 0);
          ph_q    <= PH_DRIVE;
          cnt_q   <= 5'd15;
          sgn_q   <= 1'b0;        // drive scale is unsigned
          state_q <= ST_MUL;
        end
        ST_OUT: begin
          if (out_fire) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers (no reset needed)
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        pen_q  <= in_i.pendulum_angle;
        arm_q  <= in_i.arm_angle;
        pen_dq <= 17'(in_i.pendulum_angle) - 17'(prev_pen_q);
        arm_dq <= 17'(in_i.arm_angle) - 17'(prev_arm_q);
        acc_q  <= '0;
        m_q    <= AW'(psf_pkg::to_rad(17'(in_i.arm_angle)));
        q_q    <= 24'($unsigned(gain_arm_q));
      end
      ST_MUL: begin
        acc_q <= acc_nx;
        m_q   <= m_q <<< 1;
        q_q   <= q_q >> 1;
        if (last) begin
          case (ph_q)
            PH_ARM: begin
              m_q <= AW'(pen_rad);
              q_q <= 24'($unsigned(gain_pen_q));
            end
            PH_PEN: begin
              m_q <= AW'(arm_drad);
              q_q <= gain_arm_rate_q;
            end
            PH_ARM_RATE: begin
              m_q <= AW'(pen_drad);
              q_q <= gain_pen_rate_q;
            end
            PH_PEN_RATE: begin
              fb_q  <= acc_nx;
              acc_q <= es_ext;
              m_q   <= AW'(err);
              q_q   <= 24'($unsigned(gain_int_q));
            end
            PH_DRIVE: begin
              drive_q <= drive_nx;
            end
            default: ;
          endcase
        end
      end
      ST_PREP: begin
        acc_q <= '0;
        m_q   <= mag;
        q_q   <= 24'(drive_scale_q);
      end
      default: ;
    endcase
  end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for pendulum_state_feedback_pi_unit: directed table plus random ticks.
// Predicts drive and reference per tick; depends on psf_pkg, psf_in_if, psf_out_if.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 1500000;
  localparam int DRAIN_CYCLES = 200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [psf_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [psf_pkg::CFG_W-1:0] cfg_data_i = '0;

  psf_in_if in_ch();
  psf_out_if out_ch();

  pendulum_state_feedback_pi_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_i(in_ch.sink), .out_o(out_ch.source)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // ---------------- controller model ----------------
  typedef struct packed {
    logic signed [psf_pkg::DRIVE_W-1:0] drive;
    logic signed [psf_pkg::REF_W-1:0]   refv;
  } tick_result_t;

  localparam logic signed [63:0] ERR_TOP = 64'sd140737488355327;
  localparam logic signed [63:0] ERR_BOT = -64'sd140737488355328;

  logic [23:0] gains [8];
  logic signed [63:0] m_prev_pen, m_prev_arm, m_err_sum, m_ref;
  logic m_swing;
  logic [31:0] m_ticks;
  tick_result_t drive_queue[$];

  function automatic logic signed [63:0] sx(input logic [23:0] v, input int w);
    logic signed [63:0] r;
    r = 64'(v);
    if (w < 24) r = r & ((64'sd1 <<< w) - 1);
    if (r[w-1]) r = r - (64'sd1 <<< w);
    return r;
  endfunction

  task automatic model_reset();
    gains[0] = 24'hFC14; gains[1] = 24'h375A; gains[2] = 24'hF85EAB;
    gains[3] = 24'h0DE155; gains[4] = 24'hFEEB; gains[5] = 24'd17044;
    gains[6] = 24'd3300; gains[7] = 24'd26214;
    m_prev_pen = 0; m_prev_arm = 0; m_err_sum = 0; m_ref = 0;
    m_swing = 1'b0; m_ticks = 0;
  endtask

  function automatic logic [23:0] fit_reg(input int idx, input logic [23:0] v);
    case (idx)
      2, 3: return v;
      7: return v & 24'h3FFFF;
      default: return v & 24'hFFFF;
    endcase
  endfunction

  // one control tick of the controller
  task automatic predict_tick(input logic signed [15:0] pen, input logic signed [15:0] arm,
                              input logic cv, input logic signed [7:0] cmd);
    logic signed [63:0] p, a, amp, pr, ar, pd, ad, fb, volts, err, mag, counts;
    logic [63:0] hi, lo, s;
    tick_result_t r;
    p = pen; a = arm; amp = 64'(gains[7]);
    pr = p * psf_pkg::RAD_PER_UNIT; ar = a * psf_pkg::RAD_PER_UNIT;
    pd = (p - m_prev_pen) * psf_pkg::RAD_PER_UNIT;
    ad = (a - m_prev_arm) * psf_pkg::RAD_PER_UNIT;
    if (m_ticks < 65535) m_ticks++;
    if (cv) begin
      if (cmd == psf_pkg::CMD_START) begin
        m_ref = amp; m_ticks = 0; m_swing = 1'b1;
      end else if (cmd == psf_pkg::CMD_STOP) begin
        m_ref = 0; m_swing = 1'b0;
      end else begin
        m_ref = 64'(cmd) * psf_pkg::RAD_PER_DEGREE; m_swing = 1'b0;
      end
    end
    if (m_swing && m_ticks > 32'(gains[6])) begin
      m_ref = (m_ref > 0) ? -amp : amp;
      m_ticks = 0;
    end
    fb = sx(gains[0], 16) * ar + sx(gains[1], 16) * pr + sx(gains[2], 24) * ad
       + sx(gains[3], 24) * pd;
    if (p > -psf_pkg::UPRIGHT_LIMIT && p < psf_pkg::UPRIGHT_LIMIT) begin
      err = ar - m_ref;
      m_err_sum = m_err_sum + sx(gains[4], 16) * err;
      if (m_err_sum > ERR_TOP) m_err_sum = ERR_TOP;
      if (m_err_sum < ERR_BOT) m_err_sum = ERR_BOT;
    end else begin
      m_err_sum = 0;
    end
    volts = -m_err_sum - fb * 256;
    mag = (volts < 0) ? -volts : volts;
    s = 64'(gains[5]);
    hi = 64'(mag) >> 24; lo = 64'(mag) & 64'hFFFFFF;
    counts = $signed((hi * s + ((lo * s) >> 24)) >> 16);
    if (volts < 0) r.drive = (counts > 32768) ? -16'sd32768 : 16'(-counts);
    else r.drive = (counts > 32767) ? 16'sd32767 : 16'(counts);
    r.refv = m_ref[31:0];
    m_prev_pen = p; m_prev_arm = a;
    drive_queue.push_back(r);
  endtask

  // ---------------- flow control knobs ----------------
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int mismatches = 0;
  int cycles = 0;

  // receiver: ready changes at falling edge
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // checker samples at the rising edge
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      tick_result_t want;
      if (drive_queue.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) $display("unexpected result drive=%0d", out_ch.drive_value);
      end else begin
        want = drive_queue.pop_front();
        if (want.drive !== out_ch.drive_value || want.refv !== out_ch.reference_now) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("mismatch drive exp %0d got %0d, ref exp %0d got %0d",
                     want.drive, out_ch.drive_value, want.refv, out_ch.reference_now);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  // drive one transaction; valid stays high across back-to-back items
  task automatic send_tick(input logic signed [15:0] pen, input logic signed [15:0] arm,
                           input logic cv, input logic signed [7:0] cmd);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.pendulum_angle <= pen;
    in_ch.arm_angle <= arm;
    in_ch.command_valid <= cv;
    in_ch.command <= cmd;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predict_tick(pen, arm, cv, cmd);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (drive_queue.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // enable stays high across a burst of writes; the caller drops it
  task automatic write_reg(input int idx, input logic [23:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx[psf_pkg::CFG_IDX_W-1:0];
    cfg_data_i <= v;
    @(negedge clk_i);
    gains[idx] = fit_reg(idx, v);
  endtask

  // directed ticks; expected drive/ref checked (as zero) only for the first tick after reset
  typedef struct {
    logic signed [15:0] pen;
    logic signed [15:0] arm;
    logic cv;
    logic signed [7:0] cmd;
  } tick_row_t;

  tick_row_t rows[$] = '{
    '{16'sd0, 16'sd0, 1'b0, 8'sd0},
    '{16'sd89, 16'sd0, 1'b0, 8'sd0},
    '{16'sd90, 16'sd10, 1'b0, 8'sd0},
    '{-16'sd89, -16'sd10, 1'b0, 8'sd0},
    '{-16'sd90, 16'sd5, 1'b0, 8'sd0},
    '{16'sd32767, 16'sd32767, 1'b0, 8'sd0},
    '{-16'sd32768, -16'sd32768, 1'b0, 8'sd0},
    '{16'sd32767, -16'sd32768, 1'b1, 8'sd127},
    '{16'sd0, 16'sd0, 1'b1, -8'sd128},
    '{16'sd3, 16'sd100, 1'b1, 8'sd100},
    '{16'sd3, 16'sd100, 1'b0, 8'sd0},
    '{16'sd3, 16'sd100, 1'b1, -8'sd100},
    '{16'sd1, -16'sd1, 1'b1, 8'sd45},
    '{16'sd1, -16'sd1, 1'b1, 8'sd99},
    '{16'sd1, -16'sd1, 1'b1, -8'sd101},
    '{16'sd0, 16'sd0, 1'b0, 8'sd100}
  };

  task automatic random_tick(input logic wild);
    logic signed [15:0] pen, arm;
    logic cv;
    logic signed [7:0] cmd;
    if (wild) begin
      pen = 16'($urandom); arm = 16'($urandom);
    end else begin
      pen = $signed(16'($urandom_range(200))) - 16'sd100;
      arm = $signed(16'($urandom_range(2000))) - 16'sd1000;
    end
    cv = ($urandom_range(9) == 0);
    case ($urandom_range(3))
      0: cmd = 8'sd100;
      1: cmd = -8'sd100;
      default: cmd = 8'($urandom);
    endcase
    send_tick(pen, arm, cv, cmd);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.pendulum_angle = '0;
    in_ch.arm_angle = '0;
    in_ch.command_valid = 1'b0;
    in_ch.command = '0;
    model_reset();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // first tick from reset: all zero gives zero drive and reference
    send_tick(rows[0].pen, rows[0].arm, rows[0].cv, rows[0].cmd);
    if (drive_queue[0].drive !== 16'sd0 || drive_queue[0].refv !== 32'sd0) begin
      mismatches++;
      $display("reset tick prediction not zero");
    end
    for (int i = 1; i < rows.size(); i++)
      send_tick(rows[i].pen, rows[i].arm, rows[i].cv, rows[i].cmd);
    drain();

    // phases: register settings, with short swing periods in all but phase 3 so flips happen
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin src_idle_pct = 26; snk_idle_pct = 71; end
        2: begin src_idle_pct = 71; snk_idle_pct = 26; end
        4: begin src_idle_pct = 0; snk_idle_pct = 0; end
        default: ;
      endcase
      for (int r = 0; r < 8; r++) begin
        logic [23:0] v;
        case (ph)
          0: v = 24'($urandom);
          1: v = (r == 2 || r == 3) ? 24'h800000 : ((r == 7) ? 24'h20000 : 24'h8000);
          2: v = (r == 2 || r == 3) ? 24'h7FFFFF : ((r == 7) ? 24'h0 : 24'hFFFF);
          3: v = (r == 6) ? 24'hFFFF : 24'($urandom);
          default: v = 24'($urandom);
        endcase
        if (r == 6 && ph != 3) v = 24'($urandom_range(12));
        if (r == 7 && ph == 0) v = 24'($urandom_range(131072));
        write_reg(r, v);
      end
      cfg_we_i <= 1'b0;
      for (int k = 0; k < 135; k++) begin
        random_tick($urandom_range(3) == 0);
        if (k == 60) drain();
      end
      drain();
    end

    if (mismatches == 0 && drive_queue.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// ===== pendulum_state_feedback_pi_unit.f =====
rtl/psf_pkg.sv
rtl/psf_in_if.sv
rtl/psf_out_if.sv
rtl/pendulum_state_feedback_pi_unit.sv
tb/tb_top.sv
